### rtl/vafc_pkg.sv
// vafc_pkg: shared types, constants and the arctangent table for the vector angle unit.
// No dependencies; imported by every module of the block.
package vafc_pkg;

    localparam int GUARD_BITS   = 24;   // fraction bits added below the coordinate magnitude
    localparam int ATAN_ENTRIES = 24;   // table depth; more steps add nothing
    localparam int ZW           = 19;   // angle accumulator, signed Q.16 radians
    localparam int AW           = 16;   // result angle, unsigned Q3.13

    localparam logic [AW-1:0] Q13_HALF_PI       = 16'd12868;
    localparam logic [AW-1:0] Q13_PI            = 16'd25736;
    localparam logic [AW-1:0] Q13_THREE_HALF_PI = 16'd38604;
    localparam logic [AW:0]   Q13_TWO_PI        = 17'd51472;

    // Per-item side information that rides along the pipeline with the data.
    typedef struct packed {
        logic          fixed;       // axis or zero vector: angle known up front
        logic [AW-1:0] fixed_angle;
        logic          zero;
        logic          x_neg;
        logic          y_neg;
    } meta_t;

    // atan(2^-i) * 65536, rounded to nearest; zero from entry 17 on.
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            5'd0:    val = 19'sd51472;
            5'd1:    val = 19'sd30386;
            5'd2:    val = 19'sd16055;
            5'd3:    val = 19'sd8150;
            5'd4:    val = 19'sd4091;
            5'd5:    val = 19'sd2047;
            5'd6:    val = 19'sd1024;
            5'd7:    val = 19'sd512;
            5'd8:    val = 19'sd256;
            5'd9:    val = 19'sd128;
            5'd10:   val = 19'sd64;
            5'd11:   val = 19'sd32;
            5'd12:   val = 19'sd16;
            5'd13:   val = 19'sd8;
            5'd14:   val = 19'sd4;
            5'd15:   val = 19'sd2;
            5'd16:   val = 19'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### rtl/vafc_prep.sv
// vafc_prep: input stage; sorts out axis and zero vectors, loads CORDIC start values.
// Depends on vafc_pkg.
module vafc_prep import vafc_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int DW          = 42
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic [COORD_WIDTH-1:0] x_in,
    input  logic [COORD_WIDTH-1:0] y_in,
    input  logic                   dn_ready,
    output logic                   dn_valid,
    output logic signed [DW-1:0]   cx_out,
    output logic signed [DW-1:0]   cy_out,
    output meta_t                  meta_out
);

    localparam int PAD = DW - COORD_WIDTH - GUARD_BITS;

    logic                   valid_reg;
    logic signed [DW-1:0]   cx_reg, cx_next;
    logic signed [DW-1:0]   cy_reg, cy_next;
    meta_t                  meta_reg, meta_next;
    logic [COORD_WIDTH-1:0] mx, my;
    logic                   x_zero, y_zero;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        x_zero = (x_in == '0);
        y_zero = (y_in == '0);
        // magnitude fits unsigned even for the most negative code
        mx = x_in[COORD_WIDTH-1] ? (~x_in + 1'b1) : x_in;
        my = y_in[COORD_WIDTH-1] ? (~y_in + 1'b1) : y_in;
        cx_next = signed'({{PAD{1'b0}}, mx, {GUARD_BITS{1'b0}}});
        cy_next = signed'({{PAD{1'b0}}, my, {GUARD_BITS{1'b0}}});

        meta_next.x_neg       = x_in[COORD_WIDTH-1];
        meta_next.y_neg       = y_in[COORD_WIDTH-1];
        meta_next.zero        = x_zero && y_zero;
        meta_next.fixed       = x_zero || y_zero;
        meta_next.fixed_angle = '0;
        if (x_zero && !y_zero)
            meta_next.fixed_angle = y_in[COORD_WIDTH-1] ? Q13_THREE_HALF_PI : Q13_HALF_PI;
        else if (y_zero && x_in[COORD_WIDTH-1])
            meta_next.fixed_angle = Q13_PI;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            meta_reg <= meta_next;
        end
    end

    assign dn_valid = valid_reg;
    assign cx_out   = cx_reg;
    assign cy_out   = cy_reg;
    assign meta_out = meta_reg;

endmodule

### rtl/vafc_stage.sv
// vafc_stage: one registered CORDIC vectoring iteration with a fixed shift.
// Depends on vafc_pkg.
module vafc_stage import vafc_pkg::*; #(
    parameter int DW   = 42,
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic signed [DW-1:0] cx_in,
    input  logic signed [DW-1:0] cy_in,
    input  logic signed [ZW-1:0] z_in,
    input  meta_t                meta_in,
    input  logic                 dn_ready,
    output logic                 dn_valid,
    output logic signed [DW-1:0] cx_out,
    output logic signed [DW-1:0] cy_out,
    output logic signed [ZW-1:0] z_out,
    output meta_t                meta_out
);

    logic                 valid_reg;
    logic signed [DW-1:0] cx_reg, cx_next;
    logic signed [DW-1:0] cy_reg, cy_next;
    logic signed [ZW-1:0] z_reg, z_next;
    meta_t                meta_reg;
    logic signed [DW-1:0] dx, dy;
    logic signed [ZW-1:0] step_angle;

    assign up_ready   = !valid_reg || dn_ready;
    assign step_angle = atan_q16(5'(STEP));

    always_comb
    begin
        dx = cy_in >>> STEP;   // arithmetic shift: floor
        dy = cx_in >>> STEP;
        if (!cy_in[DW-1])
        begin
            cx_next = cx_in + dx;
            cy_next = cy_in - dy;
            z_next  = z_in + step_angle;
        end
        else
        begin
            cx_next = cx_in - dx;
            cy_next = cy_in + dy;
            z_next  = z_in - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            z_reg    <= z_next;
            meta_reg <= meta_in;
        end
    end

    assign dn_valid = valid_reg;
    assign cx_out   = cx_reg;
    assign cy_out   = cy_reg;
    assign z_out    = z_reg;
    assign meta_out = meta_reg;

endmodule

### rtl/vafc_fold.sv
// vafc_fold: output stage; rounds the first-quadrant angle and folds it into its quadrant.
// Depends on vafc_pkg.
module vafc_fold import vafc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic signed [ZW-1:0] z_in,
    input  meta_t                meta_in,
    input  logic                 dn_ready,
    output logic                 dn_valid,
    output logic [AW-1:0]        angle_out,
    output logic                 zero_out
);

    logic          valid_reg;
    logic [AW-1:0] angle_reg, angle_next;
    logic          zero_reg;
    logic [ZW-1:0] z_pos, z_rnd;
    logic [ZW-4:0] a_raw;
    logic [AW-1:0] a;
    logic [AW:0]   folded;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        z_pos = z_in[ZW-1] ? '0 : unsigned'(z_in);
        z_rnd = z_pos + ZW'(4);
        a_raw = z_rnd[ZW-1:3];
        a     = (a_raw > (ZW-3)'(Q13_HALF_PI)) ? Q13_HALF_PI : a_raw[AW-1:0];

        if (!meta_in.x_neg && !meta_in.y_neg)
            folded = {1'b0, a};
        else if (meta_in.x_neg && !meta_in.y_neg)
            folded = {1'b0, Q13_PI} - {1'b0, a};
        else if (meta_in.x_neg)
            folded = {1'b0, Q13_PI} + {1'b0, a};
        else
            folded = Q13_TWO_PI - {1'b0, a};

        if (folded >= Q13_TWO_PI)
            folded = folded - Q13_TWO_PI;

        angle_next = meta_in.fixed ? meta_in.fixed_angle : folded[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            angle_reg <= angle_next;
            zero_reg  <= meta_in.zero;
        end
    end

    assign dn_valid  = valid_reg;
    assign angle_out = angle_reg;
    assign zero_out  = zero_reg;

endmodule

### rtl/vector_angle_full_circle_unit.sv
// vector_angle_full_circle_unit: full-circle angle of a signed 2D vector, CORDIC pipeline.
// Depends on vafc_pkg, vafc_prep, vafc_stage, vafc_fold.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  vec     | in        | vec_valid / vec_stall | x_coord, y_coord (signed, COORD_WIDTH)
//  res     | out       | res_valid / res_stall | angle (Q3.13 radians), zero_vector
//
// A transfer happens on a rising edge with valid high and stall low.
// One vector enters per cycle while vec_stall is low; the registers lie in this order:
// one input stage, one register per CORDIC iteration, one rounding/fold stage.
// Each stage holds its own valid bit and loads when it is empty or its successor
// loads, so bubbles are squeezed out and a stalled result does not block a
// pipeline that still has empty stages.
// Reset (rst_n, async, active low) clears only the valid bits.
module vector_angle_full_circle_unit import vafc_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   vec_valid,
    output logic                   vec_stall,
    input  logic [COORD_WIDTH-1:0] x_coord,
    input  logic [COORD_WIDTH-1:0] y_coord,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [AW-1:0]          angle,
    output logic                   zero_vector
);

    // Table ends at 24 entries; further iterations would add zero anyway.
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    // Magnitude bits + guard fraction + sign + CORDIC gain headroom.
    localparam int DW = COORD_WIDTH + GUARD_BITS + 2;

    // Index k is the output of stage k: 0 is the input stage, k>0 after iteration k-1.
    logic                 s_valid [0:NSTEPS];
    logic                 s_ready [0:NSTEPS];
    logic signed [DW-1:0] s_cx    [0:NSTEPS];
    logic signed [DW-1:0] s_cy    [0:NSTEPS];
    logic signed [ZW-1:0] s_z     [0:NSTEPS];
    meta_t                s_meta  [0:NSTEPS];
    logic                 prep_ready;
    logic                 fold_ready;

    assign vec_stall = !prep_ready;
    assign s_z[0]    = '0;   // accumulator starts at zero

    vafc_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .DW          (DW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vec_valid),
        .up_ready (prep_ready),
        .x_in     (x_coord),
        .y_in     (y_coord),
        .dn_ready (s_ready[0]),
        .dn_valid (s_valid[0]),
        .cx_out   (s_cx[0]),
        .cy_out   (s_cy[0]),
        .meta_out (s_meta[0])
    );

    // s_ready[k] means whatever consumes stage k's output loads this cycle.
    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_iter
        vafc_stage #(
            .DW   (DW),
            .STEP (k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (s_valid[k]),
            .up_ready (s_ready[k]),
            .cx_in    (s_cx[k]),
            .cy_in    (s_cy[k]),
            .z_in     (s_z[k]),
            .meta_in  (s_meta[k]),
            .dn_ready (s_ready[k+1]),
            .dn_valid (s_valid[k+1]),
            .cx_out   (s_cx[k+1]),
            .cy_out   (s_cy[k+1]),
            .z_out    (s_z[k+1]),
            .meta_out (s_meta[k+1])
        );
    end

    assign s_ready[NSTEPS] = fold_ready;

    // Final vectors are not needed; only the accumulated angle goes on.
    vafc_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s_valid[NSTEPS]),
        .up_ready  (fold_ready),
        .z_in      (s_z[NSTEPS]),
        .meta_in   (s_meta[NSTEPS]),
        .dn_ready  (!res_stall),
        .dn_valid  (res_valid),
        .angle_out (angle),
        .zero_out  (zero_vector)
    );

endmodule

### rtl/vafc_checker.sv
// vafc_checker: port-level checks on the vector angle unit, bound to the top level.
// Depends on vafc_pkg and vector_angle_full_circle_unit.
module vafc_checker import vafc_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    input logic          vec_stall,
    input logic          res_valid,
    input logic          res_stall,
    input logic [AW-1:0] angle,
    input logic          zero_vector
);

    // zero vector always reports angle 0
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && zero_vector |-> angle == '0)
        else $error("zero vector with nonzero angle");

    // angle stays in [0, 2*pi)
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> {1'b0, angle} < Q13_TWO_PI)
        else $error("angle out of range");

    // unless the output is held, every stage can move and input is open
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && res_stall) |-> !vec_stall)
        else $error("input stalled while output drains");

    // held result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(angle) && $stable(zero_vector))
        else $error("stalled result changed");

endmodule

bind vector_angle_full_circle_unit vafc_checker u_vafc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .vec_stall   (vec_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .angle       (angle),
    .zero_vector (zero_vector)
);
